### hdl/ufd_pkg.sv
// Shared types, constants and the sequence judge for the UTF-8 stream decoder.
package ufd_pkg;

   localparam logic [7:0]  CONT_MASK   = 8'hC0;
   localparam logic [7:0]  CONT_CODE   = 8'h80;
   localparam logic [20:0] LEAST_2     = 21'h000080;
   localparam logic [20:0] LEAST_3     = 21'h000800;
   localparam logic [20:0] LEAST_4     = 21'h010000;
   localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
   localparam logic [20:0] SURR_LO     = 21'h00D800;
   localparam logic [20:0] SURR_HI     = 21'h00DFFF;
   localparam logic [20:0] REPL_RESET  = 21'h00FFFD;

   // lead_len codes
   localparam logic [2:0]  LEAD_BAD    = 3'd0;
   localparam logic [2:0]  LEAD_ASCII  = 3'd1;
   localparam logic [2:0]  LEAD_TWO    = 3'd2;
   localparam logic [2:0]  LEAD_THREE  = 3'd3;
   localparam logic [2:0]  LEAD_FOUR   = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [20:0] codepoint;
      logic [2:0]  bytes_used;
      logic        replaced;
      logic        run_last;
      logic        buffer_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       cont;
      logic [2:0] lead_len;
   } byte_type;

   typedef struct packed {
      byte_type b;
      logic     fin;
   } item_type;

   typedef byte_type [3:0] win_type;

   typedef struct packed {
      logic        hold;
      logic        bad;
      logic [2:0]  used;
      logic [20:0] cp;
   } judge_type;

   function automatic judge_type judge(win_type w, logic [2:0] avail, logic fin,
                                       logic [20:0] repl);
      judge_type   r;
      logic [2:0]  len;
      logic        brk;
      logic [20:0] cp;
      logic [20:0] least;
      r.hold  = 1'b0;
      r.bad   = 1'b1;
      r.used  = 3'd1;
      r.cp    = repl;
      len     = w[0].lead_len;
      brk     = 1'b0;
      cp      = '0;
      least   = '0;
      if (len == LEAD_ASCII) begin
         r.bad = 1'b0;
         r.cp  = {13'd0, w[0].data_byte};
      end else if (len != LEAD_BAD) begin
         for (int i = 1; i < 4; i++) begin
            if (3'(i) < len && 3'(i) < avail && !w[i].cont) brk = 1'b1;
         end
         if (!brk) begin
            if (avail < len) begin
               r.hold = !fin;
            end else begin
               case (len)
                  LEAD_TWO: begin
                     cp    = {10'd0, w[0].data_byte[4:0], w[1].data_byte[5:0]};
                     least = LEAST_2;
                  end
                  LEAD_THREE: begin
                     cp    = {5'd0, w[0].data_byte[3:0], w[1].data_byte[5:0],
                              w[2].data_byte[5:0]};
                     least = LEAST_3;
                  end
                  default: begin
                     cp    = {w[0].data_byte[2:0], w[1].data_byte[5:0],
                              w[2].data_byte[5:0], w[3].data_byte[5:0]};
                     least = LEAST_4;
                  end
               endcase
               if (!(cp < least || cp > MAX_SCALAR || (cp >= SURR_LO && cp <= SURR_HI)))
               begin
                  r.bad  = 1'b0;
                  r.cp   = cp;
                  r.used = len;
               end
            end
         end
      end
      return r;
   endfunction

endpackage

### hdl/ufd_front.sv
// Front stage: accepts bytes, classifies them and pushes them into the queue.
module ufd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ufd_pkg::req_type  req_item,
   output logic              push_valid,
   output ufd_pkg::item_type push_item,
   input  logic              push_full
);
   import ufd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     advance;

   always_comb begin
      advance   = !valid_ff || !push_full;
      req_stall = !advance;
      valid_in  = valid_ff && push_full;
      item_in   = item_ff;
      if (req_valid && advance) begin
         valid_in              = 1'b1;
         item_in.b.data_byte   = req_item.data_byte;
         item_in.fin           = req_item.end_of_buffer;
         item_in.b.cont        = (req_item.data_byte & CONT_MASK) == CONT_CODE;
         if (!req_item.data_byte[7])               item_in.b.lead_len = LEAD_ASCII;
         else if (req_item.data_byte[7:5] == 3'b110)   item_in.b.lead_len = LEAD_TWO;
         else if (req_item.data_byte[7:4] == 4'b1110)  item_in.b.lead_len = LEAD_THREE;
         else if (req_item.data_byte[7:3] == 5'b11110) item_in.b.lead_len = LEAD_FOUR;
         else                                          item_in.b.lead_len = LEAD_BAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

### hdl/ufd_queue.sv
// Two-entry queue between the classifying front and the decoding back end.
module ufd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ufd_pkg::item_type push_item,
   output logic              push_full,
   input  logic              pop,
   output logic              pop_valid,
   output ufd_pkg::item_type pop_item
);
   import ufd_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      push_full = count_ff == 2'd2;
      pop_valid = count_ff != 2'd0;
      pop_item  = mem_ff[rd_ptr_ff];
      do_push   = push_valid && !push_full;
      do_pop    = pop && pop_valid;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/ufd_back.sv
// Back end: holds the byte window, judges one sequence per cycle unless loading or stalled, registers results.
module ufd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [20:0]       repl,
   input  logic              pop_valid,
   input  ufd_pkg::item_type pop_item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ufd_pkg::rsp_type  rsp_item
);
   import ufd_pkg::*;

   win_type    win_ff, win_in, shifted;
   logic [2:0] cnt_ff, cnt_in;
   logic       fin_ff, fin_in;
   logic       busy_ff, busy_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   judge_type  j, nj;
   logic       out_free, last;
   logic [2:0] rest, idx;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      pop      = !busy_ff && pop_valid;
      j        = judge(win_ff, cnt_ff, fin_ff, repl);
      rest     = cnt_ff - j.used;
      for (int i = 0; i < 4; i++) begin
         idx = 3'(i) + j.used;
         shifted[i] = (idx < 3'd4) ? win_ff[idx[1:0]] : win_ff[i];
      end
      nj   = judge(shifted, rest, fin_ff, repl);
      last = (rest == 3'd0) || nj.hold;

      win_in       = win_ff;
      cnt_in       = cnt_ff;
      fin_in       = fin_ff;
      busy_in      = busy_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (pop) begin
         win_in[cnt_ff[1:0]] = pop_item.b;
         cnt_in              = cnt_ff + 3'd1;
         fin_in              = pop_item.fin;
         busy_in             = 1'b1;
      end else if (busy_ff) begin
         if (j.hold) begin
            busy_in = 1'b0;
         end else if (out_free) begin
            win_in             = shifted;
            cnt_in             = rest;
            busy_in            = !last;
            rsp_valid_in       = 1'b1;
            rsp_in.codepoint   = j.cp;
            rsp_in.bytes_used  = j.used;
            rsp_in.replaced    = j.bad;
            rsp_in.run_last    = last;
            rsp_in.buffer_last = last && fin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff <= win_in;
      fin_ff <= fin_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### hdl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder with validation.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  ufd_pkg::req_type (byte, end of buffer)
//   rsp_     out        rsp_valid / rsp_stall  ufd_pkg::rsp_type (one decoded character)
//   csr_     in         csr_wr_en              csr_wr_data, replacement codepoint
//
// Each byte is loaded into the back end's window register, then results are released
// one by one, bound by the sequence judge. A byte passes the front register, queue
// and window register before its result is registered; front stage and 2-entry
// queue absorb bytes while the back end works or the result port stalls.
// Synchronous reset empties the window and restores the replacement to U+FFFD.
module utf8_stream_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ufd_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ufd_pkg::rsp_type rsp_item,
   input  logic             csr_wr_en,
   input  logic [20:0]      csr_wr_data
);
   import ufd_pkg::*;

   logic [20:0] repl_ff, repl_in;
   logic        push_valid, push_full, pop, pop_valid;
   item_type    push_item, pop_item;

   assign repl_in = csr_wr_en ? csr_wr_data : repl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_RESET;
      end else begin
         repl_ff <= repl_in;
      end
   end

   ufd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_full  (push_full)
   );

   ufd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_full  (push_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   ufd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .repl       (repl_ff),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

### hdl/ufd_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module ufd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ufd_pkg::rsp_type rsp_item
);
   import ufd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   a_repl_one_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.replaced |-> rsp_item.bytes_used == 3'd1)
      else $error("rejected sequence consumed more than one byte");

   a_scalar_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.replaced |->
         rsp_item.codepoint <= MAX_SCALAR &&
         !(rsp_item.codepoint >= SURR_LO && rsp_item.codepoint <= SURR_HI))
      else $error("decoded value is not a scalar value");

   a_buffer_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.buffer_last |-> rsp_item.run_last)
      else $error("buffer end without run end");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind utf8_stream_decoder ufd_checker u_ufd_checker (.*);
